// ===== hdl/irpd_pkg.sv =====
// Shared types, codes and reset values of the infrared pulse-distance transmitter.
package irpd_pkg;

  // Width of every length register; lengths are in microseconds.
  localparam int LEN_W = 16;
  // Width of the frame bit count register.
  localparam int FBITS_W = 6;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [FBITS_W-1:0] fbits_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Operation codes of a command.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_REPEAT = 2'd2;
  localparam logic [1:0] OP_STOP   = 2'd3;

  // Status codes of a response.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_NO_REPEAT = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t REG_START_BURST = 3'd0;
  localparam cfg_idx_t REG_START_SPACE = 3'd1;
  localparam cfg_idx_t REG_REPEAT_SPACE = 3'd2;
  localparam cfg_idx_t REG_MARK        = 3'd3;
  localparam cfg_idx_t REG_ZERO_SPACE  = 3'd4;
  localparam cfg_idx_t REG_ONE_SPACE   = 3'd5;
  localparam cfg_idx_t REG_STOP_BURST  = 3'd6;
  localparam cfg_idx_t REG_FRAME_BITS  = 3'd7;

  // Reset values of the configuration registers.
  localparam len_t RST_START_BURST  = 16'd9000;
  localparam len_t RST_START_SPACE  = 16'd4500;
  localparam len_t RST_REPEAT_SPACE = 16'd2250;
  localparam len_t RST_MARK         = 16'd562;
  localparam len_t RST_ZERO_SPACE   = 16'd562;
  localparam len_t RST_ONE_SPACE    = 16'd1687;
  localparam len_t RST_STOP_BURST   = 16'd562;
  localparam fbits_t RST_FRAME_BITS = 6'd32;

  // Frame phases, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_START_BURST = 7'b0000010,
    PH_START_SPACE = 7'b0000100,
    PH_BIT_MARK    = 7'b0001000,
    PH_BIT_SPACE   = 7'b0010000,
    PH_STOP_BURST  = 7'b0100000,
    PH_REP_SPACE   = 7'b1000000
  } phase_t;

  // Current configuration as seen by the sequencer.
  typedef struct packed {
    len_t   start_burst_len;
    len_t   start_space_len;
    len_t   repeat_space_len;
    len_t   mark_len;
    len_t   zero_space_len;
    len_t   one_space_len;
    len_t   stop_burst_len;
    fbits_t frame_bits;
  } cfg_t;

  // One response item.
  typedef struct packed {
    logic       carrier_active;
    logic       busy_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== hdl/irpd_if.sv =====
// Command and response channel interfaces of the infrared pulse-distance transmitter.
interface irpd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] payload;

  modport source (output valid, output operation, output payload, input ready);
  modport sink (input valid, input operation, input payload, output ready);
endinterface

interface irpd_rsp_if;
  logic       valid;
  logic       ready;
  logic       carrier_active;
  logic       busy_res;
  logic [1:0] status;

  modport source (output valid, output carrier_active, output busy_res, output status,
                  input ready);
  modport sink (input valid, input carrier_active, input busy_res, input status,
                output ready);
endinterface

// ===== hdl/ir_pulse_distance_transmitter_core.sv =====
// Top level of the infrared pulse-distance transmitter: command and response registers.
// Generates the carrier envelope of an infrared pulse-distance frame. Each command is a
// one-microsecond tick, a send of a payload word, a repeat request or a stop, and each
// command yields exactly one response carrying the carrier level, the busy flag and a
// status. The block takes one command per clock cycle when the response side keeps up;
// a command passes through the command register and its response through the response
// register. The whole phase walk for a command, including skipping phases of zero length
// and finding the next bit with a nonzero mark or space, is done combinationally by the
// phase entry resolver. The eight configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle, which
// is not enforced. DATA_BITS sets the payload shift width and TIME_BITS the phase timer.
module ir_pulse_distance_transmitter_core #(
  parameter int DATA_BITS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  irpd_cmd_if.sink            cmd,
  irpd_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  irpd_pkg::cfg_idx_t  cfg_index,
  input  irpd_pkg::len_t      cfg_data
);
  import irpd_pkg::*;

  cfg_t        cfg;
  logic        cmd_full;
  logic [1:0]  op_q;
  logic [31:0] payload_q;
  logic        step;
  logic        rsp_valid;
  res_t        res;
  res_t        res_q;

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A held command moves on when the response register is free or being emptied.
  assign step      = cmd_full && (!rsp_valid || rsp.ready);
  assign cmd.ready = !cmd_full || step;

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      cmd_full <= 1'b1;
    end else if (step) begin
      cmd_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q      <= cmd.operation;
      payload_q <= cmd.payload;
    end
  end

  irpd_seq #(
    .DATA_BITS (DATA_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .operation (op_q),
    .payload   (payload_q),
    .cfg       (cfg),
    .res       (res)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.carrier_active = res_q.carrier_active;
  assign rsp.busy_res       = res_q.busy_res;
  assign rsp.status         = res_q.status;

endmodule

// ===== hdl/irpd_cfg.sv =====
// Configuration register file of the infrared pulse-distance transmitter.
module irpd_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  irpd_pkg::cfg_idx_t cfg_index,
  input  irpd_pkg::len_t    cfg_data,
  output irpd_pkg::cfg_t    cfg
);
  import irpd_pkg::*;

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_burst_len  <= RST_START_BURST;
      cfg.start_space_len  <= RST_START_SPACE;
      cfg.repeat_space_len <= RST_REPEAT_SPACE;
      cfg.mark_len         <= RST_MARK;
      cfg.zero_space_len   <= RST_ZERO_SPACE;
      cfg.one_space_len    <= RST_ONE_SPACE;
      cfg.stop_burst_len   <= RST_STOP_BURST;
      cfg.frame_bits       <= RST_FRAME_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BURST:  cfg.start_burst_len  <= cfg_data;
        REG_START_SPACE:  cfg.start_space_len  <= cfg_data;
        REG_REPEAT_SPACE: cfg.repeat_space_len <= cfg_data;
        REG_MARK:         cfg.mark_len         <= cfg_data;
        REG_ZERO_SPACE:   cfg.zero_space_len   <= cfg_data;
        REG_ONE_SPACE:    cfg.one_space_len    <= cfg_data;
        REG_STOP_BURST:   cfg.stop_burst_len   <= cfg_data;
        REG_FRAME_BITS:   cfg.frame_bits       <= cfg_data[FBITS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/irpd_enter.sv =====
// Phase entry resolver: finds the first phase of nonzero length from an entry point.
module irpd_enter #(
  parameter int DATA_BITS = 32,
  parameter int TIME_BITS = 16,
  localparam int BW = $clog2(DATA_BITS + 1)
) (
  input  irpd_pkg::phase_t      ent,
  input  logic [BW-1:0]         idx,
  input  logic [DATA_BITS-1:0]  word,
  input  logic                  rep,
  input  irpd_pkg::cfg_t        cfg,
  output irpd_pkg::phase_t      land_phase,
  output logic [TIME_BITS-1:0]  land_time,
  output logic [BW-1:0]         land_idx
);
  import irpd_pkg::*;

  localparam int IW = $clog2(DATA_BITS);
  localparam int LW = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;
  localparam logic [LW-1:0] TMAX = LW'({TIME_BITS{1'b1}});

  logic [BW-1:0]        nbits;
  logic                 space_nz;
  len_t                 space_len;
  logic [BW-1:0]        s;
  logic [DATA_BITS-1:0] hit;
  logic [DATA_BITS-1:0] lowest;
  logic                 found;
  logic [BW-1:0]        enc;
  logic                 wsel;
  phase_t               ent2;
  logic                 go_search;
  logic                 go_stop;
  len_t                 land_len;
  logic [LW-1:0]        len_ext;

  // Number of payload bits, saturated at the word width.
  assign nbits = (int'(cfg.frame_bits) > DATA_BITS) ? BW'(DATA_BITS) : BW'(cfg.frame_bits);

  // Space length of the bit at the entry index.
  assign space_len = word[idx[IW-1:0]] ? cfg.one_space_len : cfg.zero_space_len;
  assign space_nz  = (space_len != '0);

  // Entry point after an empty start burst, and the bit where the search starts.
  always_comb begin
    ent2 = ent;
    if ((ent == PH_START_BURST) && (cfg.start_burst_len == '0)) begin
      ent2 = rep ? PH_REP_SPACE : PH_START_SPACE;
    end
    s = ((ent2 == PH_BIT_SPACE) && !space_nz) ? idx + 1'b1 : idx;
  end

  // Bits that would stop the skip over empty marks: a nonzero space inside the frame.
  always_comb begin
    for (int j = 0; j < DATA_BITS; j++) begin
      hit[j] = (BW'(j) >= s) && (BW'(j) < nbits) &&
               (word[j] ? (cfg.one_space_len != '0) : (cfg.zero_space_len != '0));
    end
  end

  // Lowest hit, encoded.
  assign lowest = hit & (~hit + 1'b1);
  assign found  = |hit;
  assign wsel   = |(lowest & word);
  always_comb begin
    enc = '0;
    for (int j = 0; j < DATA_BITS; j++) begin
      enc = enc | (lowest[j] ? BW'(j) : '0);
    end
  end

  // Walk the phase chain, skipping phases of zero length.
  always_comb begin
    go_search  = 1'b0;
    go_stop    = 1'b0;
    land_phase = PH_IDLE;
    land_len   = '0;
    land_idx   = idx;
    unique case (ent2)
      PH_START_BURST: begin
        land_phase = PH_START_BURST;
        land_len   = cfg.start_burst_len;
      end
      PH_START_SPACE: begin
        if (cfg.start_space_len != '0) begin
          land_phase = PH_START_SPACE;
          land_len   = cfg.start_space_len;
        end else begin
          go_search = 1'b1;
        end
      end
      PH_REP_SPACE: begin
        if (cfg.repeat_space_len != '0) begin
          land_phase = PH_REP_SPACE;
          land_len   = cfg.repeat_space_len;
        end else begin
          go_stop = 1'b1;
        end
      end
      PH_BIT_MARK: go_search = 1'b1;
      PH_BIT_SPACE: begin
        if (space_nz) begin
          land_phase = PH_BIT_SPACE;
          land_len   = space_len;
        end else begin
          go_search = 1'b1;
        end
      end
      PH_STOP_BURST: go_stop = 1'b1;
      default: ;
    endcase

    // Next bit with a nonzero mark or space, or the end of the data bits.
    if (go_search) begin
      if (s >= nbits) begin
        go_stop  = 1'b1;
        land_idx = s;
      end else if (cfg.mark_len != '0) begin
        land_phase = PH_BIT_MARK;
        land_len   = cfg.mark_len;
        land_idx   = s;
      end else if (found) begin
        land_phase = PH_BIT_SPACE;
        land_len   = wsel ? cfg.one_space_len : cfg.zero_space_len;
        land_idx   = enc;
      end else begin
        go_stop  = 1'b1;
        land_idx = nbits;
      end
    end

    if (go_stop && (cfg.stop_burst_len != '0)) begin
      land_phase = PH_STOP_BURST;
      land_len   = cfg.stop_burst_len;
    end
  end

  // Saturate the length to the timer range.
  assign len_ext   = LW'(land_len);
  assign land_time = (len_ext > TMAX) ? TIME_BITS'(TMAX) : TIME_BITS'(len_ext);

endmodule

// ===== hdl/irpd_seq.sv =====
// Frame sequencer: phase state, timer and bit position, updated once per command.
module irpd_seq #(
  parameter int DATA_BITS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [1:0]     operation,
  input  logic [31:0]    payload,
  input  irpd_pkg::cfg_t cfg,
  output irpd_pkg::res_t res
);
  import irpd_pkg::*;

  localparam int BW = $clog2(DATA_BITS + 1);

  phase_t               phase;
  phase_t               phase_next;
  logic [TIME_BITS-1:0] time_left;
  logic [TIME_BITS-1:0] time_left_next;
  logic [BW-1:0]        bit_index;
  logic [BW-1:0]        bit_index_next;
  logic [DATA_BITS-1:0] shift_word;
  logic [DATA_BITS-1:0] shift_word_next;
  logic                 repeat_frame;
  logic                 repeat_frame_next;

  logic                 busy;
  logic                 expire;
  logic                 do_enter;
  logic                 do_stop;
  logic                 do_dec;
  phase_t               ent;
  logic [BW-1:0]        ent_idx;
  logic [1:0]           status;
  phase_t               land_phase;
  logic [TIME_BITS-1:0] land_time;
  logic [BW-1:0]        land_idx;

  assign busy   = (phase != PH_IDLE);
  assign expire = (time_left <= TIME_BITS'(1));

  // Decode the command into an entry point or a timer step.
  always_comb begin
    do_enter          = 1'b0;
    do_stop           = 1'b0;
    do_dec            = 1'b0;
    ent               = PH_IDLE;
    ent_idx           = bit_index;
    status            = ST_OK;
    shift_word_next   = shift_word;
    repeat_frame_next = repeat_frame;
    case (operation)
      OP_TICK: begin
        if (busy) begin
          if (expire) begin
            do_enter = 1'b1;
            unique case (phase)
              PH_START_BURST: ent = repeat_frame ? PH_REP_SPACE : PH_START_SPACE;
              PH_START_SPACE: ent = PH_BIT_MARK;
              PH_BIT_MARK:    ent = PH_BIT_SPACE;
              PH_BIT_SPACE: begin
                ent     = PH_BIT_MARK;
                ent_idx = bit_index + 1'b1;
              end
              PH_REP_SPACE:   ent = PH_STOP_BURST;
              default:        ent = PH_IDLE;
            endcase
          end else begin
            do_dec = 1'b1;
          end
        end
      end
      OP_SEND: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          do_enter          = 1'b1;
          ent               = PH_START_BURST;
          ent_idx           = '0;
          shift_word_next   = DATA_BITS'(payload);
          repeat_frame_next = 1'b0;
        end
      end
      OP_REPEAT: begin
        if (busy) begin
          status = ST_BUSY;
        end else if (cfg.repeat_space_len == '0) begin
          status = ST_NO_REPEAT;
        end else begin
          do_enter          = 1'b1;
          ent               = PH_START_BURST;
          ent_idx           = '0;
          repeat_frame_next = 1'b1;
        end
      end
      default: do_stop = 1'b1;
    endcase
  end

  irpd_enter #(
    .DATA_BITS (DATA_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_enter (
    .ent        (ent),
    .idx        (ent_idx),
    .word       (shift_word_next),
    .rep        (repeat_frame_next),
    .cfg        (cfg),
    .land_phase (land_phase),
    .land_time  (land_time),
    .land_idx   (land_idx)
  );

  // Next state of the frame.
  always_comb begin
    phase_next     = phase;
    time_left_next = time_left;
    bit_index_next = bit_index;
    if (do_enter) begin
      phase_next     = land_phase;
      time_left_next = land_time;
      bit_index_next = land_idx;
    end else if (do_dec) begin
      time_left_next = time_left - 1'b1;
    end else if (do_stop) begin
      phase_next     = PH_IDLE;
      time_left_next = '0;
    end
  end

  // Response of this command, from the state it leaves.
  always_comb begin
    res.carrier_active = (phase_next == PH_START_BURST) || (phase_next == PH_BIT_MARK) ||
                         (phase_next == PH_STOP_BURST);
    res.busy_res       = (phase_next != PH_IDLE);
    res.status         = status;
  end

  // State registers, updated when a command is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      time_left    <= '0;
      bit_index    <= '0;
      shift_word   <= '0;
      repeat_frame <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      time_left    <= time_left_next;
      bit_index    <= bit_index_next;
      shift_word   <= shift_word_next;
      repeat_frame <= repeat_frame_next;
    end
  end

endmodule
